// File: src/khss_pkg.sv
`timescale 1ns / 1ps

package khss_pkg;

    localparam int DATA_W  = 8;
    localparam int HASH_W  = 32;
    localparam int SHARD_W = 16;
    localparam int ADDR_W  = 3;
    localparam int CNT_W   = 5;

    localparam logic [SHARD_W-1:0] PRIME_SMALL = 16'd7877;
    localparam logic [SHARD_W-1:0] PRIME_LARGE = 16'd65521;
    localparam logic [3:0]         HASH_MUL    = 4'd11;
    localparam logic [7:0]         LOW_MASK    = 8'hFF;
    localparam int                 FOLD_SHIFT  = 24;

    // prime reduction by folding: 2^13 = 315 (mod 7877), 2^16 = 15 (mod 65521)
    localparam int                FOLD_LO_SMALL = 13;
    localparam int                FOLD_LO_LARGE = 16;
    localparam logic [HASH_W-1:0] FOLD_K_SMALL  = 32'd315;
    localparam logic [HASH_W-1:0] FOLD_K_LARGE  = 32'd15;

    localparam logic [SHARD_W-1:0] SHARD_COUNT_RST = 16'd1;

    // prime pass: five fold steps, the last one also subtracts the prime
    localparam logic [CNT_W-1:0] STEPS_P = 5'd4;
    // shard_count pass: one dividend bit per cycle
    localparam logic [CNT_W-1:0] STEPS_C = 5'd15;

    // register word index (paddr[2])
    localparam logic REG_SHARD_COUNT = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MODP,
        S_MODC,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic accept;     // input item taken this cycle
        logic load_p;     // last byte: start prime reduction
        logic step;       // one reduction step
        logic sel_count;  // shard_count pass instead of prime pass
        logic load_c;     // prime pass done: start shard_count pass
        logic emit;       // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic last_step;  // step counter at zero
        logic out_free;   // output register can take a new item
    } t_dp_stat;

endpackage

// File: src/khss_if.sv
`timescale 1ns / 1ps

interface khss_in_if;
    logic                         valid;
    logic                         ready;
    logic [khss_pkg::DATA_W-1:0]  data_byte;
    logic                         last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface khss_out_if;
    logic                         valid;
    logic                         ready;
    logic [khss_pkg::SHARD_W-1:0] shard_id;
    logic [khss_pkg::HASH_W-1:0]  folded_hash;

    modport source (output valid, output shard_id, output folded_hash, input ready);
    modport sink   (input valid, input shard_id, input folded_hash, output ready);
endinterface

// File: src/khss_ctrl.sv
`timescale 1ns / 1ps

module khss_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    input  khss_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output khss_pkg::t_dp_cmd  o_cmd
);

    khss_pkg::t_state r_state;
    khss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= khss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            khss_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    o_cmd.load_p = 1'b1;
                    n_state      = khss_pkg::S_MODP;
                end
            end
            khss_pkg::S_MODP: begin
                o_cmd.step = 1'b1;
                if (i_stat.last_step) begin
                    o_cmd.load_c = 1'b1;
                    n_state      = khss_pkg::S_MODC;
                end
            end
            khss_pkg::S_MODC: begin
                o_cmd.step      = 1'b1;
                o_cmd.sel_count = 1'b1;
                if (i_stat.last_step) begin
                    n_state = khss_pkg::S_HOLD;
                end
            end
            khss_pkg::S_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = khss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = khss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/khss_dp.sv
`timescale 1ns / 1ps

module khss_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  khss_pkg::t_dp_cmd            i_cmd,
    input  logic [khss_pkg::DATA_W-1:0]  i_data_byte,
    input  logic [khss_pkg::SHARD_W-1:0] i_shard_count,
    input  logic                         i_out_ready,
    output khss_pkg::t_dp_stat           o_stat,
    output logic                         o_out_valid,
    output logic [khss_pkg::SHARD_W-1:0] o_shard_id,
    output logic [khss_pkg::HASH_W-1:0]  o_folded_hash
);

    localparam int HW = khss_pkg::HASH_W;
    localparam int SW = khss_pkg::SHARD_W;
    localparam int LS = khss_pkg::FOLD_LO_SMALL;
    localparam int LL = khss_pkg::FOLD_LO_LARGE;

    logic [HW-1:0]              r_hash;
    logic [HW-1:0]              r_fold;
    logic [HW-1:0]              r_div;
    logic [SW-1:0]              r_rem;
    logic [khss_pkg::CNT_W-1:0] r_cnt;
    logic                       r_out_valid;
    logic [SW-1:0]              r_out_shard;
    logic [HW-1:0]              r_out_fold;

    logic [HW-1:0] sum;
    logic [HW-1:0] n_hash;
    logic [HW-1:0] fold;
    logic [HW-1:0] red_small;
    logic [HW-1:0] red_large;
    logic [HW-1:0] red_next;
    logic [SW-1:0] prime;
    logic [HW-1:0] red_sub;
    logic [SW-1:0] n_prime_rem;
    logic [SW-1:0] divisor;
    logic [SW:0]   trial;
    logic [SW:0]   diff;
    logic [SW-1:0] n_rem;

    // h + (c<<4) + (c>>4), then *11; fold XORs the low byte into bits 31:24
    always_comb begin
        sum    = r_hash + {20'd0, i_data_byte, 4'd0} + {28'd0, i_data_byte[7:4]};
        n_hash = sum * {28'd0, khss_pkg::HASH_MUL};
        fold   = n_hash ^ {n_hash[7:0] & khss_pkg::LOW_MASK, 24'd0};
    end

    // prime pass: high part times (2^k mod p) plus low part, one fold per step;
    // five folds leave less than twice the prime
    always_comb begin
        red_small = {{LS{1'b0}}, r_div[HW-1:LS]} * khss_pkg::FOLD_K_SMALL
                  + {{(HW-LS){1'b0}}, r_div[LS-1:0]};
        red_large = {{LL{1'b0}}, r_div[HW-1:LL]} * khss_pkg::FOLD_K_LARGE
                  + {{(HW-LL){1'b0}}, r_div[LL-1:0]};
        if (i_shard_count <= khss_pkg::PRIME_SMALL) begin
            prime    = khss_pkg::PRIME_SMALL;
            red_next = red_small;
        end else begin
            prime    = khss_pkg::PRIME_LARGE;
            red_next = red_large;
        end
        red_sub = red_next - {{(HW-SW){1'b0}}, prime};
        if (red_next >= {{(HW-SW){1'b0}}, prime}) begin
            n_prime_rem = red_sub[SW-1:0];
        end else begin
            n_prime_rem = red_next[SW-1:0];
        end
    end

    // shard_count pass: restoring remainder, one dividend bit per step
    always_comb begin
        divisor = i_shard_count;
        trial   = {r_rem, r_div[HW-1]};
        diff    = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            n_rem = diff[SW-1:0];
        end else begin
            n_rem = trial[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (i_cmd.accept) begin
            r_hash <= i_cmd.load_p ? '0 : n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_p) begin
            r_fold <= fold;
            r_div  <= fold;
            r_rem  <= '0;
            r_cnt  <= khss_pkg::STEPS_P;
        end else if (i_cmd.load_c) begin
            r_div  <= {n_prime_rem, {(HW-SW){1'b0}}};
            r_rem  <= '0;
            r_cnt  <= khss_pkg::STEPS_C;
        end else if (i_cmd.step && !i_cmd.sel_count) begin
            r_div  <= red_next;
            r_cnt  <= r_cnt - 1'b1;
        end else if (i_cmd.step) begin
            r_div  <= {r_div[HW-2:0], 1'b0};
            r_rem  <= n_rem;
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            // zero shard count has no meaning; report shard 0
            r_out_shard <= (i_shard_count == '0) ? '0 : r_rem;
            r_out_fold  <= r_fold;
        end
    end

    assign o_stat.last_step = (r_cnt == '0);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_shard_id       = r_out_shard;
    assign o_folded_hash    = r_out_fold;

endmodule

// File: src/key_hash_shard_select.sv
`timescale 1ns / 1ps
// Key hash shard select.
// i_in carries key bytes (data_byte, last_byte) with valid/ready; the
// key's last byte is marked by last_byte. o_out carries one item per key:
// shard_id (below shard_count, 0 if it is 0) and the folded 32-bit hash.
// shard_count is written over the APB port at byte address 0; write it only
// while the block is idle (the block does not enforce this). It resets to 1.
// Non-last bytes are taken one per cycle. After the last byte is accepted
// the input stalls while the hash is reduced: modulo the prime (folds of
// the high part into the low part, then one conditional subtract), then
// modulo shard_count, one bit per cycle. The result reaches o_out and the
// input takes bytes again in the same cycle.
// A result that o_out does not take waits in the output register while the
// next key's bytes are still taken; that key then holds in its final state
// and keeps the input stalled until the output register frees.
// Reset (synchronous, active low) clears the running hash, any key in
// progress and the pending result.
module key_hash_shard_select (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    khss_in_if.sink                      i_in,
    khss_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [khss_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [khss_pkg::SHARD_W-1:0] r_shard_count;
    khss_pkg::t_dp_cmd             cmd;
    khss_pkg::t_dp_stat            stat;
    logic                          in_ready;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shard_count <= khss_pkg::SHARD_COUNT_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == khss_pkg::REG_SHARD_COUNT) begin
            r_shard_count <= pwdata[khss_pkg::SHARD_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == khss_pkg::REG_SHARD_COUNT) begin
            prdata = {16'd0, r_shard_count};
        end else begin
            prdata = '0;
        end
    end

    khss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_byte),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    khss_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_in.data_byte),
        .i_shard_count (r_shard_count),
        .i_out_ready   (o_out.ready),
        .o_stat        (stat),
        .o_out_valid   (o_out.valid),
        .o_shard_id    (o_out.shard_id),
        .o_folded_hash (o_out.folded_hash)
    );

    assign i_in.ready = in_ready;

endmodule

// File: src/khss_checker.sv
`timescale 1ns / 1ps

module khss_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_last,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [khss_pkg::SHARD_W-1:0] i_shard_id,
    input logic [khss_pkg::HASH_W-1:0]  i_folded_hash,
    input logic                         i_pready
);

    // reset drops any pending result
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // the reduction of a finished key blocks further bytes
    a_last_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("input ready right after last byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_shard_id) && $stable(i_folded_hash)))
        else $error("stalled output item changed");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind key_hash_shard_select khss_checker u_khss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_last     (i_in.last_byte),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_shard_id    (o_out.shard_id),
    .i_folded_hash (o_out.folded_hash),
    .i_pready      (pready)
);

// File: test/key_hash_shard_select_test.sv
`timescale 1ns / 1ps

module key_hash_shard_select_test;

    localparam int DATA_W  = khss_pkg::DATA_W;
    localparam int HASH_W  = khss_pkg::HASH_W;
    localparam int SHARD_W = khss_pkg::SHARD_W;
    localparam int ADDR_W  = khss_pkg::ADDR_W;

    localparam logic [ADDR_W-1:0] SHARD_COUNT_ADDR = {khss_pkg::REG_SHARD_COUNT, 2'b00};
    localparam int PHASES = 7;
    localparam int PHASE_BYTES = 250;
    localparam int SETTLE_CYCLES = 60;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              last;
    } t_key_byte;

    typedef struct {
        logic [SHARD_W-1:0] shard;
        logic [HASH_W-1:0]  folded;
    } t_shard_pick;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    khss_in_if  in_if ();
    khss_out_if out_if ();

    key_hash_shard_select dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_key_byte   key_bytes_to_send[$];
    t_shard_pick shard_picks_due[$];

    // predictor state
    logic [HASH_W-1:0]  key_hash;
    logic [SHARD_W-1:0] shard_count_now;

    int  error_count;
    int  bytes_sent;
    int  keys_sent;
    int  picks_checked;
    int  owed;
    int  gap_left;
    int  stall_left;
    bit  drain_hold;
    bit  idle_on;
    bit  steady;
    logic [SHARD_W-1:0] phase_count[PHASES];

    function automatic logic [HASH_W-1:0] mix_key_byte(input logic [HASH_W-1:0] h,
                                                       input logic [DATA_W-1:0] c);
        logic [HASH_W-1:0] sum;
        sum = h + (HASH_W'(c) << 4) + (HASH_W'(c) >> 4);
        return sum * HASH_W'(khss_pkg::HASH_MUL);
    endfunction

    function automatic logic [SHARD_W-1:0] shard_of(input logic [HASH_W-1:0] folded,
                                                    input logic [SHARD_W-1:0] count);
        logic [HASH_W-1:0] rem;
        if (count <= khss_pkg::PRIME_SMALL) begin
            rem = folded % HASH_W'(khss_pkg::PRIME_SMALL);
        end else begin
            rem = folded % HASH_W'(khss_pkg::PRIME_LARGE);
        end
        if (count == '0) begin
            return '0;
        end
        return SHARD_W'(rem % HASH_W'(count));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("CHECK FAILED");
        $finish;
    end

    // input driver: predicts on every accepted byte
    always @(posedge i_clk) begin
        logic take;
        logic nxt_valid;
        logic [HASH_W-1:0] folded;
        t_key_byte kb;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            key_hash = '0;
            gap_left = 0;
            owed = 0;
            drain_hold = 1'b0;
        end else begin
            take = in_if.valid && in_if.ready;
            if (take) begin
                key_hash = mix_key_byte(key_hash, in_if.data_byte);
                bytes_sent++;
                if (in_if.last_byte) begin
                    folded = key_hash ^ ({24'b0, key_hash[7:0] & khss_pkg::LOW_MASK}
                                         << khss_pkg::FOLD_SHIFT);
                    shard_picks_due.push_back('{shard_of(folded, shard_count_now), folded});
                    key_hash = '0;
                    keys_sent++;
                    owed++;
                    // now and then hold off until every result is back
                    if (idle_on && !steady && $urandom_range(0, 11) == 0) begin
                        drain_hold = 1'b1;
                    end
                end
            end
            if (out_if.valid && out_if.ready) begin
                owed--;
            end
            if (drain_hold && owed == 0) begin
                drain_hold = 1'b0;
            end
            if (take || !in_if.valid) begin
                nxt_valid = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (drain_hold || key_bytes_to_send.size() == 0) begin
                    nxt_valid = 1'b0;
                end else if (idle_on && !steady && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 8);
                end else begin
                    kb = key_bytes_to_send.pop_front();
                    in_if.data_byte <= kb.data;
                    in_if.last_byte <= kb.last;
                    nxt_valid = 1'b1;
                end
                in_if.valid <= nxt_valid;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_shard_pick want;
        logic rdy;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                picks_checked++;
                if (shard_picks_due.size() == 0) begin
                    $error("unexpected result: shard_id %0d folded_hash 0x%08h",
                           out_if.shard_id, out_if.folded_hash);
                    error_count++;
                end else begin
                    want = shard_picks_due.pop_front();
                    if (out_if.shard_id !== want.shard) begin
                        $error("shard_id: expected %0d, got %0d",
                               want.shard, out_if.shard_id);
                        error_count++;
                    end
                    if (out_if.folded_hash !== want.folded) begin
                        $error("folded_hash: expected 0x%08h, got 0x%08h",
                               want.folded, out_if.folded_hash);
                        error_count++;
                    end
                end
            end
            rdy = 1'b1;
            if (stall_left != 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (idle_on && !steady && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 8);
                rdy = 1'b0;
            end
            out_if.ready <= rdy;
        end
    end

    task automatic add_byte(input logic [DATA_W-1:0] data, input logic last);
        key_bytes_to_send.push_back('{data, last});
    endtask

    function automatic logic [DATA_W-1:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return DATA_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_random_key();
        int len;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(9, 48);
        end else begin
            len = $urandom_range(1, 8);
        end
        for (int i = 0; i < len; i++) begin
            add_byte(pick_byte(), i == len - 1);
        end
    endtask

    // block idle: nothing queued, nothing in flight, then let it settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (key_bytes_to_send.size() != 0 || in_if.valid || shard_picks_due.size() != 0
               || owed != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_shard_count(input logic [SHARD_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SHARD_COUNT_ADDR;
        pwdata  <= {16'b0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        shard_count_now = val;
        // straight into a read-back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[SHARD_W-1:0] !== val) begin
            $error("shard_count read-back: expected %0d, got %0d", val, prdata[SHARD_W-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int phase_bytes;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.last_byte = 1'b0;
        out_if.ready = 1'b0;
        error_count = 0;
        bytes_sent = 0;
        keys_sent = 0;
        picks_checked = 0;
        idle_on = 1'b1;
        steady = 1'b0;
        shard_count_now = khss_pkg::SHARD_COUNT_RST;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // shard count at its reset value: single-byte keys at both byte extremes
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        wait_drained();

        // zero shard count
        write_shard_count(16'd0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'h80, 1'b1);
        wait_drained();

        // both sides of the prime switch
        write_shard_count(khss_pkg::PRIME_SMALL);
        add_byte(8'h01, 1'b0);
        add_byte(8'h7F, 1'b1);
        wait_drained();
        write_shard_count(khss_pkg::PRIME_SMALL + 16'd1);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h55, 1'b1);
        wait_drained();

        write_shard_count(16'hFFFF);
        for (int i = 0; i < 6; i++) begin
            add_byte(8'hFF, i == 5);
        end
        wait_drained();

        phase_count[0] = SHARD_W'($urandom_range(1, 16));
        phase_count[1] = 16'd0;
        phase_count[2] = khss_pkg::PRIME_SMALL;
        phase_count[3] = khss_pkg::PRIME_SMALL + 16'd1;
        phase_count[4] = SHARD_W'($urandom_range(7879, 65534));
        phase_count[5] = 16'hFFFF;
        phase_count[6] = SHARD_W'($urandom_range(17, 7876));

        for (int p = 0; p < PHASES; p++) begin
            write_shard_count(phase_count[p]);
            idle_on = (p != 2);
            steady = (p == PHASES - 1);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                add_random_key();
                phase_bytes = key_bytes_to_send.size();
            end
            wait_drained();
        end

        $display("%0d key bytes in %0d keys sent, %0d shard picks checked",
                 bytes_sent, keys_sent, picks_checked);
        $display("shard counts covered 0, 1, 7877, 7878, 65535 and random values");
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
